[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the HEX record converter.
// Depends on nothing; the including module provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/hrpw_pkg.sv]
// Shared types, constants and the hex digit decoder of the HEX record converter.
// Depends on nothing; used by every module in rtl/core.
package hrpw_pkg;

  // Result kinds reported on the output channel.
  typedef enum logic [2:0] {
    KIND_WRITE     = 3'd0,
    KIND_DONE      = 3'd1,
    KIND_BAD_START = 3'd2,
    KIND_RANGE     = 3'd3,
    KIND_TRUNC     = 3'd4
  } kind_t;

  // Fixed field widths and record layout.
  localparam int            POS_W          = 7;
  localparam logic [6:0]    DEV_BASE       = 7'h50;
  localparam logic [7:0]    START_CHAR     = 8'h3A;
  localparam logic [POS_W-1:0] POS_START   = 7'd0;
  localparam logic [POS_W-1:0] POS_LEN_LAST  = 7'd2;
  localparam logic [POS_W-1:0] POS_ADDR_LAST = 7'd6;
  localparam logic [POS_W-1:0] POS_ADDR_DONE = 7'd7;
  localparam logic [POS_W-1:0] POS_DATA_FIRST = 7'd9;

  // Output queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_LW    = 3;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [6:0]  device_select;
    logic [8:0]  mem_address;
    logic [7:0]  data_byte;
    logic        burst_end;
    logic [7:0]  saved_count;
  } res_t;

  // Fill status of the output queue.
  typedef struct packed {
    logic [FIFO_LW-1:0] level;
    logic               room2;
  } fifo_stat_t;

  // Decode one ASCII hex digit; anything else reads as zero.
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end
    return v[3:0];
  endfunction

endpackage

[rtl/core/hrpw_decoder.sv]
// Per-character record decoder: line state, range check, write and status generation.
// Depends on hrpw_pkg.
module hrpw_decoder #(
  parameter int MEM_BYTES  = 512,
  parameter int PAGE_BYTES = 16,
  parameter int LINE_CHARS = 123
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       character,
  input  logic             line_end,
  output logic             wr_valid,
  output hrpw_pkg::res_t   wr_res,
  output logic             st_valid,
  output hrpw_pkg::res_t   st_res
);

  localparam int PW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam logic [PW-1:0] PAGE_LAST = PW'(PAGE_BYTES - 1);
  localparam logic [PW:0]   PAGE_SIZE = (PW + 1)'(PAGE_BYTES);
  localparam logic [16:0]   MEM_SIZE  = 17'(MEM_BYTES);
  localparam logic [hrpw_pkg::POS_W-1:0] POS_LIMIT = hrpw_pkg::POS_W'(LINE_CHARS);

  logic [hrpw_pkg::POS_W-1:0] char_position, char_position_next;
  logic [7:0]                 record_length, record_length_next;
  logic [15:0]                record_address, record_address_next;
  logic [3:0]                 high_nibble, high_nibble_next;
  logic [7:0]                 bytes_done, bytes_done_next;
  logic                       err_flag, err_flag_next;
  hrpw_pkg::kind_t            err_kind, err_kind_next;
  logic [PW-1:0]              page_off, page_off_next;

  logic [3:0]   digit;
  logic [15:0]  addr_shifted;
  logic [16:0]  addr_end;
  logic         out_of_range;
  logic [PW-1:0] addr_mod;
  logic         page_end;

  assign digit        = hrpw_pkg::hex_digit(character);
  assign addr_shifted = {record_address[11:0], digit};
  assign addr_end     = {1'b0, addr_shifted} + {9'd0, record_length};
  assign out_of_range = ({1'b0, addr_shifted} >= MEM_SIZE) || (addr_end > MEM_SIZE);
  assign page_end     = (page_off == PAGE_LAST);

  // Address modulo page size, folded in one bit at a time as address digits arrive.
  always_comb begin
    logic [PW:0]   t;
    logic [PW-1:0] r;
    r = page_off;
    for (int i = 3; i >= 0; i--) begin
      t = {r, digit[i]};
      if (t >= PAGE_SIZE) begin
        t = t - PAGE_SIZE;
      end
      r = t[PW-1:0];
    end
    addr_mod = r;
  end

  // Next line state and the results of the current character.
  always_comb begin
    char_position_next  = char_position;
    record_length_next  = record_length;
    record_address_next = record_address;
    high_nibble_next    = high_nibble;
    bytes_done_next     = bytes_done;
    err_flag_next       = err_flag;
    err_kind_next       = err_kind;
    page_off_next       = page_off;
    wr_valid            = 1'b0;
    st_valid            = 1'b0;
    wr_res.kind          = hrpw_pkg::KIND_WRITE;
    wr_res.device_select = hrpw_pkg::DEV_BASE | {5'd0, record_address[8], 1'b0};
    wr_res.mem_address   = record_address[8:0];
    wr_res.data_byte     = {high_nibble, digit};
    wr_res.burst_end     = (({1'b0, bytes_done} + 9'd1) == {1'b0, record_length}) || page_end;
    wr_res.saved_count   = 8'd0;
    st_res.kind          = hrpw_pkg::KIND_DONE;
    st_res.device_select = hrpw_pkg::DEV_BASE;
    st_res.mem_address   = 9'd0;
    st_res.data_byte     = 8'd0;
    st_res.burst_end     = 1'b0;
    st_res.saved_count   = 8'd0;

    if (step) begin
      if (char_position < POS_LIMIT) begin
        if (!err_flag) begin
          if (char_position == hrpw_pkg::POS_START) begin
            if (character != hrpw_pkg::START_CHAR) begin
              err_flag_next = 1'b1;
              err_kind_next = hrpw_pkg::KIND_BAD_START;
            end
          end else if (char_position <= hrpw_pkg::POS_LEN_LAST) begin
            record_length_next = {record_length[3:0], digit};
          end else if (char_position <= hrpw_pkg::POS_ADDR_LAST) begin
            record_address_next = addr_shifted;
            page_off_next       = addr_mod;
            if (char_position == hrpw_pkg::POS_ADDR_LAST && out_of_range) begin
              err_flag_next = 1'b1;
              err_kind_next = hrpw_pkg::KIND_RANGE;
            end
          end else if (char_position >= hrpw_pkg::POS_DATA_FIRST) begin
            // Odd positions carry the high digit, even ones complete the byte.
            if (bytes_done < record_length) begin
              if (char_position[0]) begin
                high_nibble_next = digit;
              end else begin
                wr_valid            = 1'b1;
                bytes_done_next     = bytes_done + 8'd1;
                record_address_next = record_address + 16'd1;
                page_off_next       = page_end ? '0 : page_off + PW'(1);
              end
            end
          end
        end
        char_position_next = char_position + 7'd1;
      end

      // The last character reports the line status and clears the state.
      if (line_end) begin
        st_valid = 1'b1;
        if (err_flag_next) begin
          st_res.kind = err_kind_next;
        end else if (char_position_next < hrpw_pkg::POS_ADDR_DONE ||
                     bytes_done_next < record_length_next) begin
          st_res.kind        = hrpw_pkg::KIND_TRUNC;
          st_res.saved_count = bytes_done_next;
        end else begin
          st_res.saved_count = record_length_next;
        end
        char_position_next  = '0;
        record_length_next  = '0;
        record_address_next = '0;
        high_nibble_next    = '0;
        bytes_done_next     = '0;
        err_flag_next       = 1'b0;
        err_kind_next       = hrpw_pkg::KIND_WRITE;
        page_off_next       = '0;
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= '0;
      record_length  <= '0;
      record_address <= '0;
      high_nibble    <= '0;
      bytes_done     <= '0;
      err_flag       <= 1'b0;
      err_kind       <= hrpw_pkg::KIND_WRITE;
      page_off       <= '0;
    end else begin
      char_position  <= char_position_next;
      record_length  <= record_length_next;
      record_address <= record_address_next;
      high_nibble    <= high_nibble_next;
      bytes_done     <= bytes_done_next;
      err_flag       <= err_flag_next;
      err_kind       <= err_kind_next;
      page_off       <= page_off_next;
    end
  end

endmodule

[rtl/core/hrpw_out_fifo.sv]
// Four-entry result queue that takes up to two results a cycle and gives one.
// Depends on hrpw_pkg.
module hrpw_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push0,
  input  hrpw_pkg::res_t        res0,
  input  logic                  push1,
  input  hrpw_pkg::res_t        res1,
  input  logic                  pop,
  output logic                  head_valid,
  output hrpw_pkg::res_t        head,
  output hrpw_pkg::fifo_stat_t  stat
);

  hrpw_pkg::res_t entries [hrpw_pkg::FIFO_DEPTH];

  logic [hrpw_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [hrpw_pkg::FIFO_LW-1:0] level, level_next;
  hrpw_pkg::res_t               first;
  logic                         any_push, two_push, do_pop;

  assign first    = push0 ? res0 : res1;
  assign any_push = push0 | push1;
  assign two_push = push0 & push1;
  assign do_pop   = pop & head_valid;

  // Level after this cycle's pushes and pop.
  always_comb begin
    level_next = level + {2'd0, any_push} + {2'd0, two_push} - {2'd0, do_pop};
  end

  // Result storage; the first result goes in ahead of the second.
  always_ff @(posedge clk) begin
    if (any_push) begin
      entries[wr_ptr] <= first;
    end
    if (two_push) begin
      entries[wr_ptr + 2'd1] <= res1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + {1'b0, any_push} + {1'b0, two_push};
      rd_ptr <= rd_ptr + {1'b0, do_pop};
      level  <= level_next;
    end
  end

  assign head_valid = (level != '0);
  assign head       = entries[rd_ptr];
  assign stat.level = level;
  assign stat.room2 = (level <= hrpw_pkg::FIFO_LW'(hrpw_pkg::FIFO_DEPTH - 2));

endmodule

[rtl/core/hex_record_to_page_writes_unit.sv]
// Top level of the HEX record to page-write converter.
// Depends on hrpw_pkg, hrpw_decoder, hrpw_out_fifo and assert_macros.svh.
//
// The input channel takes one character of a HEX record line per request,
// with line_end set on the last character of the line. The output channel
// gives byte writes (address, device select, data, burst end) and one status
// request per line (done, bad start, out of range or truncated).
// A character is held in an input register and decoded once the output
// queue has room for two results; its results are registered in a
// four-entry output queue and given from its head. One character may
// cause up to two results: a final byte write followed by the status.
// Throughput is one character per cycle while the queue has room for two.
// in_ready falls only while the output queue has fewer than two free
// entries, so a receiver that stalls holds the input side back once the
// queue fills.
// Reset clears the line state, the input register and the queue; the block
// is ready in the first cycle after reset.
`include "assert_macros.svh"

module hex_record_to_page_writes_unit #(
  parameter int MEM_BYTES  = 512,
  parameter int PAGE_BYTES = 16,
  parameter int LINE_CHARS = 123
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [6:0] device_select,
  output logic [8:0] mem_address,
  output logic [7:0] data_byte,
  output logic       burst_end,
  output logic [7:0] saved_count
);

  logic                 q_valid;
  logic [7:0]           q_char;
  logic                 q_end;
  logic                 advance;
  logic                 wr_valid, st_valid;
  hrpw_pkg::res_t       wr_res, st_res, head;
  hrpw_pkg::fifo_stat_t fifo_stat;

  // A held character is decoded once the queue has room for two results.
  assign advance  = q_valid & fifo_stat.room2;
  assign in_ready = ~q_valid | fifo_stat.room2;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_char <= character;
      q_end  <= line_end;
    end
  end

  hrpw_decoder #(
    .MEM_BYTES  (MEM_BYTES),
    .PAGE_BYTES (PAGE_BYTES),
    .LINE_CHARS (LINE_CHARS)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .character (q_char),
    .line_end  (q_end),
    .wr_valid  (wr_valid),
    .wr_res    (wr_res),
    .st_valid  (st_valid),
    .st_res    (st_res)
  );

  hrpw_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (wr_valid),
    .res0       (wr_res),
    .push1      (st_valid),
    .res1       (st_res),
    .pop        (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .stat       (fifo_stat)
  );

  // Output fields straight from the queue head.
  assign kind          = head.kind;
  assign device_select = head.device_select;
  assign mem_address   = head.mem_address;
  assign data_byte     = head.data_byte;
  assign burst_end     = head.burst_end;
  assign saved_count   = head.saved_count;

  // Checks on the queue, the input register and the result encoding.
  `ASSERT_CLK(a_level_max, fifo_stat.level <= 3'(hrpw_pkg::FIFO_DEPTH), "queue overfilled")
  `ASSERT_CLK(a_take_holds, in_valid && in_ready |=> q_valid, "taken character was lost")
  `ASSERT_CLK(a_dev_bit, out_valid && kind == hrpw_pkg::KIND_WRITE |-> device_select[1] == mem_address[8], "device select does not match address block")
  `ASSERT_CLK(a_status_clean, out_valid && kind != hrpw_pkg::KIND_WRITE |-> mem_address == 9'd0 && !burst_end, "status request carries write fields")

endmodule
